// File: rtl/tcf_pkg.sv
// Shared constants, types and helper functions of the tilt complementary filter.
`timescale 1ns / 1ps

package tcf_pkg;

	// Algorithm constants
	localparam int CORDIC_STEPS    = 16;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int ACC_FRAC        = 24;
	localparam int TAB_LEN         = 24;
	localparam int TAB_IDX_W       = 5;
	localparam int STEP_W          = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	// Field and datapath widths
	localparam int ACCEL_W  = 16;
	localparam int RATE_W   = 24;
	localparam int DT_W     = 24;
	localparam int ANGLE_W  = 26;
	localparam int ALPHA_W  = 17;
	localparam int INIT_W   = 25;
	localparam int CFG_W    = 25;
	localparam int XY_W     = 33;
	localparam int ACC_W    = 34;
	localparam int GPROD_W  = RATE_W + DT_W + 1;
	// gyro step after the format shift, plus the angle, plus one carry bit
	localparam int GYRO_W   = ((GPROD_W - 32 + ANGLE_FRAC_BITS > ANGLE_W) ?
		GPROD_W - 32 + ANGLE_FRAC_BITS : ANGLE_W) + 1;
	localparam int PA_W     = ALPHA_W + 1 + GYRO_W;
	localparam int PB_W     = ALPHA_W + 1 + ANGLE_W;
	localparam int WIDE_W   = PA_W + 1;
	localparam int IN_SCALE = 14;

	// Shift amounts between fixed-point formats
	localparam int ACC_SHIFT  = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam int GYRO_SHIFT = 32 - ANGLE_FRAC_BITS;
	localparam int MIX_SHIFT  = 16;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(64225);
	localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(180) <<< ACC_FRAC;

	// Configuration register indexes
	localparam logic CFG_ALPHA = 1'b0;
	localparam logic CFG_INIT  = 1'b1;

	// How the angle register is updated at the end of a transaction
	typedef enum logic [1:0] {
		COMMIT_NONE,
		COMMIT_REARM,
		COMMIT_SEED,
		COMMIT_BLEND
	} commit_t;

	// Controller to datapath commands
	typedef struct packed {
		logic              capture;
		logic              start;
		logic              step;
		logic [STEP_W-1:0] step_idx;
		logic              angle;
		logic              mul_a;
		logic              mul_b;
		commit_t           commit;
		logic              out_load;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic rearm;
		logic dt_zero;
		logic seeded;
	} dp_status_t;

	// atan(2^-i) in 2^-24 degree
	function automatic logic signed [ACC_W-1:0] atan_lut(input logic [TAB_IDX_W-1:0] i);
		logic signed [ACC_W-1:0] r;
		case (i)
			5'd0:    r = ACC_W'(754974720);
			5'd1:    r = ACC_W'(445687602);
			5'd2:    r = ACC_W'(235489088);
			5'd3:    r = ACC_W'(119537938);
			5'd4:    r = ACC_W'(60000934);
			5'd5:    r = ACC_W'(30029717);
			5'd6:    r = ACC_W'(15018523);
			5'd7:    r = ACC_W'(7509720);
			5'd8:    r = ACC_W'(3754917);
			5'd9:    r = ACC_W'(1877466);
			5'd10:   r = ACC_W'(938734);
			5'd11:   r = ACC_W'(469367);
			5'd12:   r = ACC_W'(234684);
			5'd13:   r = ACC_W'(117342);
			5'd14:   r = ACC_W'(58671);
			5'd15:   r = ACC_W'(29335);
			5'd16:   r = ACC_W'(14668);
			5'd17:   r = ACC_W'(7334);
			5'd18:   r = ACC_W'(3667);
			5'd19:   r = ACC_W'(1833);
			5'd20:   r = ACC_W'(917);
			5'd21:   r = ACC_W'(458);
			5'd22:   r = ACC_W'(229);
			5'd23:   r = ACC_W'(115);
			default: r = '0;
		endcase
		return r;
	endfunction

	// Clamp a wide signed value to the angle range
	function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		logic signed [ANGLE_W-1:0] r;
		hi = WIDE_W'($signed({1'b0, {(ANGLE_W-1){1'b1}}}));
		lo = WIDE_W'($signed({1'b1, {(ANGLE_W-1){1'b0}}}));
		if (v > hi) begin
			r = hi[ANGLE_W-1:0];
		end else if (v < lo) begin
			r = lo[ANGLE_W-1:0];
		end else begin
			r = v[ANGLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/tilt_complementary_filter.sv
// Top level of the accelerometer and gyro tilt complementary filter.
`timescale 1ns / 1ps
//
// Channel   Direction  Payload
// s_*       in         tuser = cmd; tdata = accel_x, accel_z, gyro_rate, dt
// m_*       out        tuser = primed; tdata = angle (zero padded to 32 bits)
// cfg_*     in         write-only: index 0 alpha, index 1 initial_angle
//
// A sample update with nonzero dt runs decode, CORDIC_STEPS rotations of the
// one-rotation-per-cycle CORDIC unit, the angle step, the three sequential
// multiplies, commit and write up to m_tvalid; a seeding sample skips the two
// blend multiplies. Rearm and zero-dt transactions go from decode to write.
// One transaction is in work at a time; s_tready is high only while idle, so
// a new sample waits until the last result sits in the output register, where
// a stalled result holds the controller until it is taken. Reset is asynchronous.

module tilt_complementary_filter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [79:0]               s_tdata,  // accel_x, accel_z, gyro_rate, dt
	input  logic                      s_tuser,  // cmd
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,  // angle, 6 zero bits
	output logic                      m_tuser,  // primed
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [tcf_pkg::CFG_W-1:0] cfg_data
);
	import tcf_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	tcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	tcf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (dp_cmd),
		.status    (dp_status)
	);

endmodule

// File: rtl/tcf_ctrl.sv
// Sequencing state machine of the tilt filter: handshakes, CORDIC count, commit.
`timescale 1ns / 1ps

module tcf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  tcf_pkg::dp_status_t status,
	output tcf_pkg::dp_cmd_t    cmd
);
	import tcf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CORDIC,
		ST_ANGLE,
		ST_MULA,
		ST_MULB,
		ST_COMMIT,
		ST_WRITE
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              m_tvalid_d;
	logic              out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;

	// Next state and command decode
	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		m_tvalid_d = m_tvalid && !m_tready;
		cmd        = '0;
		cmd.commit = COMMIT_NONE;
		cmd.step_idx = step_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.start = 1'b1;
				step_d    = '0;
				if (status.rearm) begin
					cmd.commit = COMMIT_REARM;
					state_d    = ST_WRITE;
				end else if (status.dt_zero) begin
					state_d = ST_WRITE;
				end else begin
					state_d = ST_CORDIC;
				end
			end
			ST_CORDIC: begin
				cmd.step = 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					state_d = ST_ANGLE;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_ANGLE: begin
				cmd.angle = 1'b1;
				state_d   = status.seeded ? ST_MULA : ST_COMMIT;
			end
			ST_MULA: begin
				cmd.mul_a = 1'b1;
				state_d   = ST_MULB;
			end
			ST_MULB: begin
				cmd.mul_b = 1'b1;
				state_d   = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = status.seeded ? COMMIT_BLEND : COMMIT_SEED;
				state_d    = ST_WRITE;
			end
			ST_WRITE: begin
				// wait for the output register to drain
				if (out_free) begin
					cmd.out_load = 1'b1;
					m_tvalid_d   = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q  <= state_d;
			step_q   <= step_d;
			m_tvalid <= m_tvalid_d;
		end
	end

endmodule

// File: rtl/tcf_datapath.sv
// Datapath of the tilt filter: CORDIC vectoring unit, gyro and blend multipliers, state.
`timescale 1ns / 1ps

module tcf_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic                                    cfg_index,
	input  logic [tcf_pkg::CFG_W-1:0]               cfg_data,
	input  logic [79:0]                             s_tdata,
	input  logic                                    s_tuser,
	output logic [31:0]                             m_tdata,
	output logic                                    m_tuser,
	input  tcf_pkg::dp_cmd_t                        cmd,
	output tcf_pkg::dp_status_t                     status
);
	import tcf_pkg::*;

	// Configuration
	logic [ALPHA_W-1:0]       alpha_q;
	logic signed [INIT_W-1:0] init_q;

	// Captured transaction
	logic                     rearm_q;
	logic signed [ACCEL_W-1:0] ax_q, az_q;
	logic signed [RATE_W-1:0] rate_q;
	logic [DT_W-1:0]          dt_q;

	// Working registers
	logic signed [XY_W-1:0]    x_q, y_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      zero_q;
	logic signed [GPROD_W-1:0] gprod_q;
	logic signed [ANGLE_W-1:0] acc_ang_q;
	logic signed [GYRO_W-1:0]  gyro_q;
	logic signed [PA_W-1:0]    pa_q;
	logic signed [PB_W-1:0]    pb_q;

	// Filter state and output register
	logic signed [ANGLE_W-1:0] tilt_q;
	logic                      seeded_q;
	logic signed [ANGLE_W-1:0] angle_q;
	logic                      primed_q;

	// Combinational helpers
	logic [ALPHA_W-1:0]        alpha_eff, alpha_rest;
	logic signed [XY_W-1:0]    ax_e, az_e, x_init, y_init;
	logic signed [XY_W-1:0]    dx, dy;
	logic signed [ACC_W-1:0]   acc_init, atan_i, acc_shr;
	logic signed [GPROD_W-1:0] gprod_full, gprod_shr;
	logic signed [PA_W-1:0]    pa_full;
	logic signed [PB_W-1:0]    pb_full;
	logic signed [WIDE_W-1:0]  mix, mix_shr;

	assign status.rearm   = rearm_q;
	assign status.dt_zero = (dt_q == '0);
	assign status.seeded  = seeded_q;

	assign m_tdata = {{(32-ANGLE_W){1'b0}}, angle_q};
	assign m_tuser = primed_q;

	// Alpha clamped to one and its complement
	assign alpha_eff  = alpha_q[ALPHA_W-1] ? ALPHA_ONE : alpha_q;
	assign alpha_rest = ALPHA_ONE - alpha_eff;

	// CORDIC start: fold the left half plane by a half turn
	always_comb begin
		ax_e = XY_W'(ax_q);
		az_e = XY_W'(az_q);
		if (az_q < 0) begin
			x_init   = -az_e;
			y_init   = -ax_e;
			acc_init = (ax_q >= 0) ? HALF_TURN : -HALF_TURN;
		end else begin
			x_init   = az_e;
			y_init   = ax_e;
			acc_init = '0;
		end
	end

	// One micro-rotation per cycle
	assign dx     = y_q >>> cmd.step_idx;
	assign dy     = x_q >>> cmd.step_idx;
	assign atan_i = atan_lut(TAB_IDX_W'(cmd.step_idx));

	// Products and format shifts
	assign gprod_full = rate_q * $signed({1'b0, dt_q});
	assign gprod_shr  = gprod_q >>> GYRO_SHIFT;
	assign acc_shr    = acc_q >>> ACC_SHIFT;
	assign pa_full    = $signed({1'b0, alpha_eff}) * gyro_q;
	assign pb_full    = $signed({1'b0, alpha_rest}) * acc_ang_q;
	assign mix        = WIDE_W'(pa_q) + WIDE_W'(pb_q);
	assign mix_shr    = mix >>> MIX_SHIFT;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			init_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ALPHA: alpha_q <= cfg_data[ALPHA_W-1:0];
				CFG_INIT:  init_q  <= $signed(cfg_data[INIT_W-1:0]);
			endcase
		end
	end

	// Payload and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rearm_q <= s_tuser;
			ax_q    <= $signed(s_tdata[15:0]);
			az_q    <= $signed(s_tdata[31:16]);
			rate_q  <= $signed(s_tdata[55:32]);
			dt_q    <= s_tdata[79:56];
		end
		if (cmd.start) begin
			x_q     <= x_init <<< IN_SCALE;
			y_q     <= y_init <<< IN_SCALE;
			acc_q   <= acc_init;
			zero_q  <= (ax_q == 0) && (az_q == 0);
			gprod_q <= gprod_full;
		end
		if (cmd.step) begin
			if (!y_q[XY_W-1]) begin
				x_q   <= x_q + dx;
				y_q   <= y_q - dy;
				acc_q <= acc_q + atan_i;
			end else begin
				x_q   <= x_q - dx;
				y_q   <= y_q + dy;
				acc_q <= acc_q - atan_i;
			end
		end
		if (cmd.angle) begin
			acc_ang_q <= zero_q ? '0 : sat_angle(WIDE_W'(acc_shr));
			gyro_q    <= GYRO_W'(gprod_shr) + GYRO_W'(tilt_q);
		end
		if (cmd.mul_a) begin
			pa_q <= pa_full;
		end
		if (cmd.mul_b) begin
			pb_q <= pb_full;
		end
		if (cmd.out_load) begin
			angle_q  <= tilt_q;
			primed_q <= seeded_q;
		end
	end

	// Filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_q   <= '0;
			seeded_q <= 1'b0;
		end else begin
			case (cmd.commit)
				COMMIT_REARM: begin
					tilt_q   <= ANGLE_W'(init_q);
					seeded_q <= 1'b0;
				end
				COMMIT_SEED: begin
					tilt_q   <= acc_ang_q;
					seeded_q <= 1'b1;
				end
				COMMIT_BLEND: tilt_q <= sat_angle(mix_shr);
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/tcf_checker.sv
// Port-level assertions of the tilt filter and their binding to the top level.
`timescale 1ns / 1ps

module tcf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// One transaction in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a transaction is in work");

	// A new result only comes out of a busy sequencer
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a transaction in work");

	// Stalled result stays offered
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	// Stalled result payload holds
	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
